/* design/erf_pkg.sv */
// constants, widths and shared types of the encoder unwrap and rate filter
`default_nettype none
package erf_pkg;

  localparam int AVERAGE_DEPTH    = 6;
  localparam int WRAP_LIMIT       = 6400;
  localparam int COUNTS_PER_TURN  = 8192;
  localparam int DEGREES_PER_TURN = 360;

  localparam int POS_W   = 13;
  localparam int TURN_W  = 16;
  localparam int RATE_W  = 14;
  localparam int CPOS_W  = 30;
  localparam int ANGLE_W = 38;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 112;

  // running sum of the rates in the window
  localparam int SUM_W     = $clog2(WRAP_LIMIT * AVERAGE_DEPTH + 1) + 1;
  localparam int SUM_ABS_W = SUM_W - 1;

  // divide by the window length as multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT  = SUM_ABS_W + $clog2(AVERAGE_DEPTH);
  localparam int DIV_MULT   = ((1 << DIV_SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
  localparam int DIV_MULT_W = SUM_ABS_W + 2;
  localparam int PROD_W     = SUM_ABS_W + DIV_MULT_W;

  localparam logic signed [TURN_W-1:0] TURNS_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURNS_MIN = {1'b1, {(TURN_W-1){1'b0}}};

  typedef struct packed {
    logic signed [TURN_W-1:0] turns;
    logic        [POS_W-1:0]  reading;
    logic signed [RATE_W-1:0] rate;
    logic signed [SUM_W-1:0]  sum;
  } erf_stage_t;

endpackage
`default_nettype wire

/* design/erf_rate_cell.sv */
// one cell of the rate window: holds one rate and passes it on per item
`default_nettype none
module erf_rate_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              shift_i,
  input  wire logic signed [erf_pkg::RATE_W-1:0] rate_i,
  output logic signed [erf_pkg::RATE_W-1:0]      rate_o
);
  import erf_pkg::*;

  logic signed [RATE_W-1:0] rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (shift_i) begin
      rate_q <= rate_i;
    end
  end

  assign rate_o = rate_q;

endmodule
`default_nettype wire

/* design/erf_out_stage.sv */
// output register: average, raw rate, turn count, continuous position and scaled angle
`default_nettype none
module erf_out_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           valid_i,
  input  wire erf_pkg::erf_stage_t            stage_i,
  input  wire logic [erf_pkg::POS_W-1:0]      angle_bias_i,
  output logic                                ready_o,
  output logic                                m_valid_o,
  input  wire logic                           m_ready_i,
  output logic [erf_pkg::M_TDATA_W-1:0]       m_data_o
);
  import erf_pkg::*;

  logic                        valid_q;
  logic [M_TDATA_W-1:0]        data_q;
  logic                        take;
  logic signed [SUM_W-1:0]     sum_neg;
  logic [SUM_ABS_W-1:0]        sum_abs;
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-1:0]           quo_full;
  logic [RATE_W-1:0]           quo;
  logic signed [RATE_W-1:0]    filtered;
  logic signed [CPOS_W-1:0]    cpos;
  logic signed [CPOS_W-1:0]    rel;
  logic signed [ANGLE_W-1:0]   rel_x;
  logic signed [ANGLE_W-1:0]   angle;

  assign ready_o = !valid_q || m_ready_i;
  assign take    = valid_i && ready_o;

  // truncation toward zero: divide the magnitude, then restore the sign
  assign sum_neg  = -stage_i.sum;
  assign sum_abs  = stage_i.sum[SUM_W-1] ? sum_neg[SUM_ABS_W-1:0]
                                         : stage_i.sum[SUM_ABS_W-1:0];
  assign prod     = PROD_W'(sum_abs) * PROD_W'(DIV_MULT);
  assign quo_full = prod >> DIV_SHIFT;
  assign quo      = quo_full[RATE_W-1:0];
  assign filtered = stage_i.sum[SUM_W-1] ? -$signed(quo) : $signed(quo);

  assign cpos  = {{(CPOS_W-TURN_W-POS_W){stage_i.turns[TURN_W-1]}},
                  stage_i.turns, stage_i.reading};
  assign rel   = cpos - $signed({{(CPOS_W-POS_W){1'b0}}, angle_bias_i});
  assign rel_x = {{(ANGLE_W-CPOS_W){rel[CPOS_W-1]}}, rel};
  assign angle = rel_x * $signed(ANGLE_W'(DEGREES_PER_TURN));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= {angle, filtered, stage_i.rate, cpos, stage_i.turns};
    end
  end

  assign m_valid_o = valid_q;
  assign m_data_o  = data_q;

endmodule
`default_nettype wire

/* design/encoder_unwrap_rate_filter.sv */
// encoder unwrap, turn counting and moving-average rate filter, top level
//
//   channel   dir  fields (low bit first)
//   s_axis    in   raw_position[12:0], zero pad to 16 bits
//   m_axis    out  turn_count, continuous_position, raw_rate, filtered_rate,
//                  angle_scaled (112 bits)
//   cfg       in   angle_bias[12:0], written when cfg_we_i is high
//
// one item per cycle unless m_axis stalls; results pass a_q, then data_q;
// the unwrap and running sum close in the accept cycle, the window of rates
// is a row of cells shifted once per item, and the divide and angle scale
// sit in the output register; reset clears turns, previous reading, sum and
// every cell at once, so items are taken from the first cycle after reset
// a stall on m_axis holds the output and backs up through s_axis_tready
`default_nettype none
module encoder_unwrap_rate_filter (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // raw_position[12:0]
  input  wire logic [erf_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // turn_count[15:0], continuous_position[45:16], raw_rate[59:46],
  // filtered_rate[73:60], angle_scaled[111:74]
  output logic [erf_pkg::M_TDATA_W-1:0]         m_axis_tdata,
  input  wire logic                             cfg_we_i,
  input  wire logic [erf_pkg::POS_W-1:0]        cfg_wdata_i
);
  import erf_pkg::*;

  localparam logic signed [RATE_W-1:0] WRAP_POS = RATE_W'(WRAP_LIMIT);
  localparam logic signed [RATE_W-1:0] TURN_CNT = RATE_W'(COUNTS_PER_TURN);

  logic [POS_W-1:0]         bias_q;
  logic [POS_W-1:0]         prev_q;
  logic signed [TURN_W-1:0] turns_q, turns_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic                     a_valid_q;
  erf_stage_t               a_q;
  logic                     out_ready;
  logic                     accept;
  logic [POS_W-1:0]         reading;
  logic signed [RATE_W-1:0] diff;
  logic signed [RATE_W-1:0] rate;
  logic                     wrap_fwd, wrap_bwd;
  logic signed [RATE_W-1:0] chain [AVERAGE_DEPTH+1];

  assign reading       = s_axis_tdata[POS_W-1:0];
  assign s_axis_tready = !a_valid_q || out_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign diff     = $signed({1'b0, reading}) - $signed({1'b0, prev_q});
  assign wrap_fwd = diff < -WRAP_POS;
  assign wrap_bwd = diff > WRAP_POS;

  always_comb begin
    turns_d = turns_q;
    rate    = diff;
    if (wrap_fwd) begin
      rate = diff + TURN_CNT;
      if (turns_q != TURNS_MAX) begin
        turns_d = turns_q + $signed(TURN_W'(1));
      end
    end else if (wrap_bwd) begin
      rate = diff - TURN_CNT;
      if (turns_q != TURNS_MIN) begin
        turns_d = turns_q - $signed(TURN_W'(1));
      end
    end
  end

  // window of rates: newest enters cell 0, oldest leaves the last cell
  assign chain[0] = rate;
  for (genvar k = 0; k < AVERAGE_DEPTH; k++) begin : g_cell
    erf_rate_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (accept),
      .rate_i  (chain[k]),
      .rate_o  (chain[k+1])
    );
  end

  assign sum_d = sum_q + SUM_W'(rate) - SUM_W'(chain[AVERAGE_DEPTH]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q    <= '0;
      prev_q    <= '0;
      turns_q   <= '0;
      sum_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bias_q <= cfg_wdata_i;
      end
      if (accept) begin
        prev_q    <= reading;
        turns_q   <= turns_d;
        sum_q     <= sum_d;
        a_valid_q <= 1'b1;
      end else if (out_ready) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q.turns   <= turns_d;
      a_q.reading <= reading;
      a_q.rate    <= rate;
      a_q.sum     <= sum_d;
    end
  end

  erf_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (a_valid_q),
    .stage_i      (a_q),
    .angle_bias_i (bias_q),
    .ready_o      (out_ready),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_o     (m_axis_tdata)
  );

endmodule
`default_nettype wire

/* design/erf_checker.sv */
// port-level checks on the encoder unwrap and rate filter, bound to the top
`default_nettype none
module erf_port_assert (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [erf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import erf_pkg::*;

  // a stalled item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output item dropped while stalled");

  a_raw_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[59:46]) >= -14'sd6400) &&
                      ($signed(m_axis_tdata[59:46]) <= 14'sd6400))
    else $error("raw rate beyond wrap limit");

  a_filtered_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[73:60]) >= -14'sd6400) &&
                      ($signed(m_axis_tdata[73:60]) <= 14'sd6400))
    else $error("filtered rate beyond wrap limit");

  // upper bits of the continuous position are the sign-extended turn count
  a_position_turns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[44:29] == m_axis_tdata[15:0]) &&
                      (m_axis_tdata[45] == m_axis_tdata[15]))
    else $error("continuous position disagrees with turn count");

  // with the output side free the input side never stalls
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready && $past(m_axis_tready) |-> s_axis_tready)
    else $error("input stalled with output free");

endmodule

bind encoder_unwrap_rate_filter erf_port_assert u_erf_port_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* bench/erf_checker.sv */
// result checker for the encoder unwrap and rate filter: predicts each readout and compares
`default_nettype none
module erf_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  input  wire logic                          s_axis_tready,
  input  wire logic [erf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  input  wire logic [erf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  wire logic                          cfg_we_i,
  input  wire logic [erf_pkg::POS_W-1:0]     cfg_wdata_i,
  output int                                 mismatch_count_o,
  output int                                 pending_o
);
  import erf_pkg::*;

  // lowest field last, so the packing matches m_axis_tdata
  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [RATE_W-1:0]  filtered;
    logic signed [RATE_W-1:0]  rate;
    logic signed [CPOS_W-1:0]  position;
    logic signed [TURN_W-1:0]  turns;
  } readout_t;

  logic        [POS_W-1:0]  bias = '0;
  logic        [POS_W-1:0]  last_reading = '0;
  logic signed [TURN_W-1:0] turn_total = '0;
  logic signed [RATE_W-1:0] rate_window [AVERAGE_DEPTH];
  int                       window_slot = 0;
  int                       window_sum = 0;
  int                       mismatches = 0;
  readout_t                 expected_readouts [$];

  function automatic readout_t unwrap_reading(input logic [POS_W-1:0] reading);
    int       jump;
    int       rate;
    int       average;
    longint   position;
    longint   angle;
    readout_t r;
    jump = int'(reading) - int'(last_reading);
    if (jump < -WRAP_LIMIT) begin
      if (turn_total < TURNS_MAX) turn_total = turn_total + 16'sd1;
      rate = jump + COUNTS_PER_TURN;
    end else if (jump > WRAP_LIMIT) begin
      if (turn_total > TURNS_MIN) turn_total = turn_total - 16'sd1;
      rate = jump - COUNTS_PER_TURN;
    end else begin
      rate = jump;
    end
    last_reading = reading;
    position = longint'(reading) + longint'(turn_total) * COUNTS_PER_TURN;
    angle = longint'(DEGREES_PER_TURN) *
            (longint'(reading) - longint'(bias) + longint'(turn_total) * COUNTS_PER_TURN);
    // running sum over the window, oldest rate drops out
    window_sum = window_sum + rate - int'(rate_window[window_slot]);
    rate_window[window_slot] = RATE_W'(rate);
    window_slot = (window_slot + 1) % AVERAGE_DEPTH;
    average = window_sum / AVERAGE_DEPTH;
    r.turns    = turn_total;
    r.position = CPOS_W'(position);
    r.rate     = RATE_W'(rate);
    r.filtered = RATE_W'(average);
    r.angle    = ANGLE_W'(angle);
    return r;
  endfunction

  task automatic compare_field(input string field, input longint want, input longint seen);
    if (want != seen) begin
      if (mismatches < 10)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    readout_t want;
    readout_t seen;
    if (!rst_ni) begin
      bias = '0;
      last_reading = '0;
      turn_total = '0;
      for (int i = 0; i < AVERAGE_DEPTH; i++) rate_window[i] = '0;
      window_slot = 0;
      window_sum = 0;
      expected_readouts.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seen = m_axis_tdata;
        if (expected_readouts.size() == 0) begin
          if (mismatches < 10) $display("%0t: readout with no item waiting", $time);
          mismatches++;
        end else begin
          want = expected_readouts.pop_front();
          compare_field("turn_count", longint'(want.turns), longint'(seen.turns));
          compare_field("continuous_position", longint'(want.position),
                        longint'(seen.position));
          compare_field("raw_rate", longint'(want.rate), longint'(seen.rate));
          compare_field("filtered_rate", longint'(want.filtered), longint'(seen.filtered));
          compare_field("angle_scaled", longint'(want.angle), longint'(seen.angle));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_readouts.push_back(unwrap_reading(s_axis_tdata[POS_W-1:0]));
      if (cfg_we_i) bias = cfg_wdata_i;
    end
    pending_o = expected_readouts.size();
    mismatch_count_o = mismatches;
  end

endmodule
`default_nettype wire

/* bench/encoder_unwrap_rate_filter_test.sv */
// testbench top for the encoder unwrap and rate filter: stimulus, watchdog and verdict
`default_nettype none
module encoder_unwrap_rate_filter_test;
  import erf_pkg::*;

  localparam int PAD_W       = S_TDATA_W - POS_W;
  localparam int STALL_LIMIT = 2000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [POS_W-1:0]      cfg_wdata_i = '0;

  int                    mismatch_count;
  int                    readouts_pending;
  int                    quiet_cycles = 0;
  bit                    steady = 1'b0;
  logic [POS_W-1:0]      last_sent = '0;

  encoder_unwrap_rate_filter i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  erf_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatch_count),
    .pending_o        (readouts_pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 6);
  end

  // ends the run when no item moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic [S_TDATA_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < 6) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    // tready is settled by the falling edge, so the item goes at the next rising one
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    last_sent = word[POS_W-1:0];
  endtask

  task automatic feed_reading(input logic [POS_W-1:0] reading);
    send_word({PAD_W'($urandom), reading});
  endtask

  task automatic step_reading(input int delta);
    feed_reading(POS_W'(int'(last_sent) + delta));
  endtask

  task automatic drain_readouts();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (readouts_pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_bias(input logic [POS_W-1:0] value);
    drain_readouts();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // three items per turn, touching the exact wrap limit on the way
  task automatic turn_forward(input int count);
    feed_reading('0);
    repeat (count) begin
      feed_reading(POS_W'(WRAP_LIMIT));
      feed_reading('1);
      feed_reading('0);
    end
  endtask

  task automatic turn_backward(input int count);
    feed_reading('0);
    repeat (count) begin
      feed_reading('1);
      feed_reading(POS_W'(COUNTS_PER_TURN - 1 - WRAP_LIMIT));
      feed_reading('0);
    end
  endtask

  task automatic wander(input int count);
    int pick;
    int span;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_word(S_TDATA_W'($urandom));
      end else if (pick < 20) begin
        // jumps right at and around the wrap limit
        case ($urandom_range(0, 5))
          0: step_reading(WRAP_LIMIT);
          1: step_reading(-WRAP_LIMIT);
          2: step_reading(WRAP_LIMIT + 1);
          3: step_reading(-WRAP_LIMIT - 1);
          4: step_reading(WRAP_LIMIT - 1);
          default: step_reading(1 - WRAP_LIMIT);
        endcase
      end else begin
        span = (pick < 60) ? 64 : (pick < 85) ? 1500 : WRAP_LIMIT;
        step_reading(int'($urandom_range(0, 2 * span)) - span);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first item above the limit counts as a backward wrap
    feed_reading(13'd7000);
    feed_reading(13'd600);
    feed_reading(13'd7000);
    feed_reading(13'd599);
    feed_reading(13'd7001);
    send_word({{PAD_W{1'b1}}, {POS_W{1'b1}}});
    send_word('0);
    feed_reading('1);
    feed_reading('1);
    feed_reading('0);
    feed_reading(13'd1);
    feed_reading(13'd4096);
    feed_reading('0);
    write_bias('1);
    feed_reading('0);
    feed_reading('1);
    feed_reading(13'd4096);

    wander(450);
    write_bias(POS_W'($urandom));
    steady <= 1'b1;
    wander(450);
    steady <= 1'b0;
    write_bias('0);
    wander(450);

    // whole turns each way
    turn_forward(3);
    write_bias('1);
    turn_backward(6);
    write_bias(POS_W'($urandom));
    turn_forward(3);
    wander(100);

    drain_readouts();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* sim.f */
design/erf_pkg.sv
design/erf_rate_cell.sv
design/erf_out_stage.sv
design/encoder_unwrap_rate_filter.sv
design/erf_checker.sv
bench/erf_checker.sv
bench/encoder_unwrap_rate_filter_test.sv
